// File: rtl/core/srsc_pkg.sv
`default_nettype none

package srsc_pkg;

  // Parameter defaults
  localparam int STACK_DEPTH_DEF = 2048;
  localparam int ADDR_WIDTH_DEF  = 32;

  // Depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // Input field widths and positions in in_tdata
  localparam int PC_W        = 32;
  localparam int SIZE_W      = 3;
  localparam int RET_W       = 32;
  localparam int PC_LSB      = 0;
  localparam int SIZE_LSB    = PC_LSB + PC_W;
  localparam int RET_LSB     = SIZE_LSB + SIZE_W;
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 1;

  // Output field widths
  localparam int STATUS_W    = 3;
  localparam int CNT_W       = 12;
  localparam int EXP_W       = 32;
  localparam int FAIL_W      = 32;
  localparam int OUT_TDATA_W = 96;

  // action codes carried on in_tuser
  localparam logic ACT_CALL   = 1'b0;
  localparam logic ACT_RETURN = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_TOP       = 3'd1,
    ST_ABOVE     = 3'd2,
    ST_UNWOUND   = 3'd3,
    ST_MISMATCH  = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_UNDERFLOW = 3'd6
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/shadow_return_stack_checker.sv
// Throughput: the back end runs one item at a time, and a return that searches
//   the store reads one stored entry per cycle.
// Reset: synchronous, active low; afterwards the store is zeroed at one entry
//   per cycle, with in_tready low until the pass ends.
`default_nettype none

module shadow_return_stack_checker
  import srsc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  // input items
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // call_pc[31:0], insn_size[34:32],
                                                  // observed_return[66:35], zero pad
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // action[0]: 0 call, 1 return

  // result items
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // status[2:0], unwind_count[14:3],
                                                  // depth_after[26:15],
                                                  // expected_return[58:27],
                                                  // failures[90:59], zero pad
);

  // Front -> queue -> back. The front classifies each transfer and forms the
  // address to push or to check; the back owns the shadow stack memory,
  // depth pointer and failure counter and runs one item at a time.
  logic                  q_valid;
  logic [ADDR_WIDTH:0]   q_data;   // {is_return, address}
  logic                  q_pop;
  logic                  clearing;

  srsc_front #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  // Back end sequence per return: read top, read slot above top, then walk
  // down from two below the depth to index 1, one entry per cycle. Results
  // sit in an output register so the next item proceeds while one waits.
  srsc_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/srsc_ram.sv
`default_nettype none

module srsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/srsc_fifo.sv
`default_nettype none

module srsc_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  not_empty,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/srsc_front.sv
`default_nettype none

module srsc_front
  import srsc_pkg::*;
#(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [IN_TUSER_W-1:0] in_tuser,
  input  wire logic                  clearing,
  output logic                       q_valid,
  output logic [ADDR_WIDTH:0]        q_data,
  input  wire logic                  q_pop
);

  logic                  q_full;
  logic                  is_ret;
  logic [PC_W-1:0]       call_pc;
  logic [SIZE_W-1:0]     insn_size;
  logic [RET_W-1:0]      observed_return;
  logic [ADDR_WIDTH-1:0] push_addr;
  logic [ADDR_WIDTH-1:0] item_addr;

  assign call_pc         = in_tdata[PC_LSB +: PC_W];
  assign insn_size       = in_tdata[SIZE_LSB +: SIZE_W];
  assign observed_return = in_tdata[RET_LSB +: RET_W];
  assign is_ret          = (in_tuser[0] == ACT_RETURN);

  // expected return: pc + size + 1 (mode bit), wraps at the address width
  assign push_addr = ADDR_WIDTH'(call_pc) + ADDR_WIDTH'(insn_size) + ADDR_WIDTH'(1);
  assign item_addr = is_ret ? ADDR_WIDTH'(observed_return) : push_addr;

  assign in_tready = !q_full && !clearing;

  srsc_fifo #(
    .WIDTH (ADDR_WIDTH + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_data ({is_ret, item_addr}),
    .full      (q_full),
    .not_empty (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

endmodule

`default_nettype wire

// File: rtl/core/srsc_back.sv
`default_nettype none

module srsc_back
  import srsc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire logic [ADDR_WIDTH:0]    q_data,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int AW = ADDR_WIDTH;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_TOP    = 6'b000100,
    S_ABOVE  = 6'b001000,
    S_SEARCH = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic [FAIL_W-1:0]      fail_r, fail_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic                   is_ret_r, is_ret_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [AW-1:0]          top_r, top_nxt;
  status_t                status_r, status_nxt;
  logic [DW-1:0]          unwind_r, unwind_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_wdata;
  logic [IW-1:0]          ram_raddr;
  logic [AW-1:0]          ram_rdata;

  logic                   has_top;
  logic                   above_ok;
  logic                   hit;

  assign has_top  = (depth_r != '0);
  assign above_ok = (depth_r < DW'(STACK_DEPTH));
  assign hit      = (ram_rdata == addr_r) || (ram_rdata == (addr_r | AW'(1)));
  assign clearing = (state_r == S_CLEAR);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  srsc_ram #(
    .WIDTH (AW),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    fail_nxt      = fail_r;
    idx_nxt       = idx_r;
    is_ret_nxt    = is_ret_r;
    addr_nxt      = addr_r;
    top_nxt       = top_r;
    status_nxt    = status_r;
    unwind_nxt    = unwind_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == IW'(STACK_DEPTH - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      S_IDLE: begin
        ram_raddr = has_top ? IW'(depth_r - DW'(1)) : '0;
        if (q_valid) begin
          q_pop      = 1'b1;
          is_ret_nxt = q_data[AW];
          addr_nxt   = q_data[AW-1:0];
          state_nxt  = S_TOP;
        end
      end

      S_TOP: begin
        top_nxt    = has_top ? ram_rdata : '0;
        ram_raddr  = above_ok ? depth_r[IW-1:0] : '0;
        unwind_nxt = '0;
        if (!is_ret_r) begin
          if (above_ok) begin
            ram_we     = 1'b1;
            ram_waddr  = depth_r[IW-1:0];
            ram_wdata  = addr_r;
            depth_nxt  = depth_r + DW'(1);
            status_nxt = ST_PUSHED;
          end else begin
            status_nxt = ST_OVERFLOW;
          end
          state_nxt = S_RESP;
        end else if (has_top && hit) begin
          depth_nxt  = depth_r - DW'(1);
          status_nxt = ST_TOP;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_ABOVE;
        end
      end

      S_ABOVE: begin
        // first search read: entry two below the depth
        ram_raddr = IW'(depth_r - DW'(2));
        idx_nxt   = IW'(depth_r - DW'(2));
        if (above_ok && hit) begin
          depth_nxt  = depth_r + DW'(1);
          status_nxt = ST_ABOVE;
          state_nxt  = S_RESP;
        end else if (depth_r > DW'(2)) begin
          state_nxt = S_SEARCH;
        end else if (!has_top) begin
          status_nxt = ST_UNDERFLOW;
          state_nxt  = S_RESP;
        end else begin
          depth_nxt  = depth_r - DW'(1);
          fail_nxt   = fail_r + FAIL_W'(1);
          status_nxt = ST_MISMATCH;
          state_nxt  = S_RESP;
        end
      end

      S_SEARCH: begin
        ram_raddr = idx_r - IW'(1);
        idx_nxt   = idx_r - IW'(1);
        if (hit) begin
          depth_nxt  = DW'(idx_r);
          unwind_nxt = depth_r - DW'(1) - DW'(idx_r);
          status_nxt = ST_UNWOUND;
          state_nxt  = S_RESP;
        end else if (idx_r == IW'(1)) begin
          // index 0 is never searched; search range exhausted
          depth_nxt  = depth_r - DW'(1);
          fail_nxt   = fail_r + FAIL_W'(1);
          status_nxt = ST_MISMATCH;
          state_nxt  = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({fail_r, EXP_W'(top_r), CNT_W'(depth_r),
                                        CNT_W'(unwind_r), status_r});
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      depth_r     <= '0;
      fail_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      fail_r      <= fail_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_ret_r   <= is_ret_nxt;
    addr_r     <= addr_nxt;
    top_r      <= top_nxt;
    status_r   <= status_nxt;
    unwind_r   <= unwind_nxt;
    out_data_r <= out_data_nxt;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_call_keeps_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TOP) && !is_ret_r |=> $stable(fail_r))
    else $error("call changed failure count");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && (status_r == ST_UNDERFLOW) |-> depth_r == '0)
    else $error("underflow reported on non-empty stack");

endmodule

`default_nettype wire

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srsc_pkg::*;

  localparam int ADDR_W      = ADDR_WIDTH_DEF;
  localparam int STACK_DEPTH = STACK_DEPTH_DEF;

  // Stop point for the whole run. It covers the store clearing pass after
  // reset, a few full-depth searches, and every item waiting out random gaps
  // and stalls on both sides, several times over.
  localparam int CYCLE_LIMIT  = 500_000;
  // Quiet cycles after the last result, to catch stray transfers.
  localparam int DRAIN_CYCLES = 64;
  // Keep the log short if the block goes badly wrong.
  localparam int MAX_REPORTS  = 100;

  // One branch event as the block sees it.
  typedef struct {
    logic              act;
    bit [PC_W-1:0]     pc;
    bit [SIZE_W-1:0]   size;
    bit [RET_W-1:0]    ret;
  } branch_item_t;

  // One verdict as the block reports it.
  typedef struct {
    status_t           status;
    bit [CNT_W-1:0]    unwind;
    bit [CNT_W-1:0]    depth;
    bit [EXP_W-1:0]    top;
    bit [FAIL_W-1:0]   fails;
  } verdict_t;

  // Shadow copy of the return stack plus the verdicts still owed by the block.
  class ret_verdict_board;
    bit [ADDR_W-1:0] store [STACK_DEPTH];
    int unsigned     depth;
    bit [FAIL_W-1:0] fails;
    verdict_t        expected_verdicts [$];

    function new();
      foreach (store[i]) store[i] = '0;
      depth = 0;
      fails = '0;
    endfunction

    // An entry stands for an address with or without the mode bit.
    function bit addr_hit(bit [ADDR_W-1:0] entry, bit [ADDR_W-1:0] addr);
      return (entry == addr) || (entry == (addr | 1));
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // Called for every accepted input transfer.
    function void note_branch(branch_item_t it);
      verdict_t        v;
      int unsigned     d;
      int unsigned     i;
      bit [ADDR_W-1:0] top;
      bit              done;
      d = depth;
      top = (d > 0) ? store[d-1] : '0;
      v.unwind = '0;
      done = 1'b0;
      if (it.act == ACT_CALL) begin
        if (d >= STACK_DEPTH) begin
          v.status = ST_OVERFLOW;
        end else begin
          // the sum wraps at the address width
          store[d] = it.pc + ADDR_W'(it.size) + ADDR_W'(1);
          d++;
          v.status = ST_PUSHED;
        end
      end else begin
        if (d > 0 && addr_hit(top, it.ret)) begin
          d--;
          v.status = ST_TOP;
          done = 1'b1;
        end else if (d < STACK_DEPTH && addr_hit(store[d], it.ret)) begin
          // stale slot just above the top, e.g. a repeated return
          d++;
          v.status = ST_ABOVE;
          done = 1'b1;
        end else begin
          // search stops at index 1, the bottom entry is never a target
          for (i = 1; !done && i + 1 < d; i++) begin
            if (addr_hit(store[d-1-i], it.ret)) begin
              v.unwind = CNT_W'(i);
              d = d - i - 1;
              v.status = ST_UNWOUND;
              done = 1'b1;
            end
          end
        end
        if (!done) begin
          if (d == 0) begin
            v.status = ST_UNDERFLOW;
          end else begin
            d--;
            fails++;
            v.status = ST_MISMATCH;
          end
        end
      end
      depth = d;
      v.depth = CNT_W'(d);
      v.top = top;
      v.fails = fails;
      expected_verdicts.push_back(v);
    endfunction

    // Compares one output transfer with the oldest owed verdict.
    function bit check_verdict(verdict_t got, output string why);
      verdict_t want;
      why = "";
      if (expected_verdicts.size() == 0) begin
        why = " result with nothing pending";
        return 1'b0;
      end
      want = expected_verdicts.pop_front();
      if (got.status !== want.status)
        why = {why, $sformatf(" status %0d want %0d", got.status, want.status)};
      if (got.unwind !== want.unwind)
        why = {why, $sformatf(" unwind_count %0d want %0d", got.unwind, want.unwind)};
      if (got.depth !== want.depth)
        why = {why, $sformatf(" depth_after %0d want %0d", got.depth, want.depth)};
      if (got.top !== want.top)
        why = {why, $sformatf(" expected_return %h want %h", got.top, want.top)};
      if (got.fails !== want.fails)
        why = {why, $sformatf(" failures %0d want %0d", got.fails, want.fails)};
      return (why.len() == 0);
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  ret_verdict_board sb;
  int               cycle       = 0;
  int               mismatches  = 0;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;

  shadow_return_stack_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // call_pc, insn_size, observed_return, zero pad
    .in_tuser   (in_tuser),   // action
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // status, unwind_count, depth_after,
                              // expected_return, failures, zero pad
  );

  always #6 clk = ~clk;

  // Run watchdog.
  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("cycle %0d:%s", cycle, msg);
  endtask

  // Receiver: random back-pressure, updated on the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Result checker, sampled on the rising edge.
  always @(posedge clk) begin
    verdict_t got;
    string    why;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[2:0]);
      got.unwind = out_tdata[14:3];
      got.depth  = out_tdata[26:15];
      got.top    = out_tdata[58:27];
      got.fails  = out_tdata[90:59];
      if (!sb.check_verdict(got, why))
        report_mismatch(why);
    end
  end

  // Mostly the usual 2 and 4 byte calls, sometimes any 3-bit size.
  function automatic bit [SIZE_W-1:0] pick_size();
    if ($urandom_range(9) < 8)
      return $urandom_range(1) ? SIZE_W'(2) : SIZE_W'(4);
    return SIZE_W'($urandom_range(7));
  endfunction

  // Unused fields get random values so every field bit of the input toggles.
  function automatic branch_item_t call_item(bit [PC_W-1:0] pc, bit [SIZE_W-1:0] size);
    branch_item_t it;
    it.act  = ACT_CALL;
    it.pc   = pc;
    it.size = size;
    it.ret  = $urandom;
    return it;
  endfunction

  function automatic branch_item_t ret_item(bit [RET_W-1:0] addr);
    branch_item_t it;
    it.act  = ACT_RETURN;
    it.pc   = $urandom;
    it.size = SIZE_W'($urandom_range(7));
    it.ret  = addr;
    return it;
  endfunction

  // Stored address, sometimes with the mode bit dropped as a real return would.
  function automatic bit [RET_W-1:0] entry_addr(int unsigned idx);
    bit [RET_W-1:0] a;
    a = sb.store[idx];
    if ($urandom_range(1)) a[0] = 1'b0;
    return a;
  endfunction

  // Random traffic that tracks the shadow stack: mostly nested call/return
  // pairs, plus repeated returns, unwinds and wild addresses. Depth stays
  // shallow so the searches stay short.
  function automatic branch_item_t make_branch();
    int unsigned d;
    int unsigned pick;
    d = sb.depth;
    pick = $urandom_range(99);
    if ((d < 2 && pick < 70) || (d < 48 && pick < 45) || pick < 15)
      return call_item($urandom, pick_size());
    pick = $urandom_range(99);
    if (d > 0 && pick < 60)
      return ret_item(entry_addr(d - 1));
    if (d < STACK_DEPTH && pick < 72)
      return ret_item(entry_addr(d));
    if (d > 2 && pick < 88)
      return ret_item(entry_addr($urandom_range(d - 2, 1)));
    return ret_item($urandom);
  endfunction

  // Entered and left at a falling edge. One transfer per call.
  task automatic push_branch(branch_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.act;
    in_tdata  <= {5'b0, it.ret, it.size, it.pc};
    do @(posedge clk); while (!in_tready);
    sb.note_branch(it);
    @(negedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) push_branch(make_branch());
  endtask

  // Sender holds off until every owed verdict is back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Full-stack corner: fill, overflow, returns on a full stack, then one
  // deep unwind back to the bottom so the random traffic stays shallow.
  task automatic fill_and_unwind();
    bit [RET_W-1:0] a;
    while (sb.depth < STACK_DEPTH) push_branch(call_item($urandom, pick_size()));
    repeat (3) push_branch(call_item($urandom, pick_size()));
    a = entry_addr(STACK_DEPTH - 1);
    push_branch(ret_item(a));            // top match, one slot free
    push_branch(ret_item(a));            // same address again, above-top refills
    push_branch(ret_item($urandom));     // full stack: no slot above, long search
    push_branch(call_item($urandom, pick_size()));
    push_branch(ret_item(entry_addr(1)));
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 30;
    rx_idle_pct = 45;

    // Directed: empty stack, wrap of the pushed sum, odd sizes, each status but overflow.
    push_branch(ret_item(32'hFFFF_FFFF));        // underflow on empty stack
    push_branch(ret_item(32'h0000_0000));        // slot 0 still checked when empty
    push_branch(ret_item(32'h0000_0000));        // top match back to empty
    push_branch(call_item(32'hFFFF_FFFF, 3'd4)); // sum wraps to 4
    push_branch(call_item(32'hFFFF_FFFE, 3'd0));
    push_branch(call_item(32'h0000_0000, 3'd7));
    push_branch(call_item(32'h0000_1000, 3'd2));
    push_branch(call_item(32'h0000_2000, 3'd4));
    push_branch(ret_item(32'h0000_2004));        // top match, mode bit dropped
    push_branch(ret_item(32'h0000_2005));        // above-top match
    push_branch(ret_item(32'hFFFF_FFFE));        // unwind three entries
    push_branch(ret_item(32'h1234_5678));        // mismatch down to empty
    push_branch(ret_item(32'h1234_5678));        // underflow, stale slot 0
    push_branch(call_item(32'h0000_0040, 3'd1));
    push_branch(call_item(32'h0000_0080, 3'd3));
    push_branch(call_item(32'h0000_00C0, 3'd5));
    push_branch(call_item(32'h0000_0100, 3'd6));
    push_branch(ret_item(32'h0000_0042));        // bottom entry is not searched
    push_branch(ret_item(32'h0000_00C6));
    push_branch(ret_item(32'h8000_0000));        // plain mismatch
    push_branch(ret_item(32'h0000_0042));

    run_random(550);
    wait_drained();

    tx_idle_pct = 45;
    rx_idle_pct = 30;
    run_random(550);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(250);
    fill_and_unwind();
    run_random(250);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
